@@ hdl/gfmac_pkg.sv @@
// ---------------------------------------------------------------------------
// gfmac_pkg
// Types, constants and GF(2^8) helpers for the region multiply-accumulate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gfmac_pkg;

  localparam int WORD_W    = 64;
  localparam int IDX_W     = 15;
  localparam int LANE_W    = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  localparam logic [8:0] GF_POLY = 9'o435;

  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 8'd1;

  typedef enum logic [1:0] {
    MODE_XOR     = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_SEARCH  = 2'd2,
    MODE_DIVIDE  = 2'd3
  } mode_t;

  // queue entry from front to back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              nz_any;
    logic [IDX_W-1:0]  nz_idx;
    logic              search;
    logic              last;
  } entry_t;

  typedef logic [7:0] inv_tbl_t [256];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    acc = 8'd0;
    x   = {1'b0, a};
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return acc;
  endfunction

  function automatic inv_tbl_t gen_inv_tbl();
    inv_tbl_t   t;
    logic [7:0] r;
    logic [7:0] p;
    logic [7:0] e;
    for (int a = 0; a < 256; a++) begin
      r = 8'd1;
      p = 8'(a);
      e = 8'd254;
      for (int k = 0; k < 8; k++) begin
        if (e[0]) begin
          r = gf_mul(r, p);
        end
        p = gf_mul(p, p);
        e = e >> 1;
      end
      t[a] = r;
    end
    return t;
  endfunction

  localparam inv_tbl_t GF_INV = gen_inv_tbl();

endpackage

@@ hdl/gf256_region_multiply_accumulate_top.sv @@
// Path: an accepted input is written into the queue by the front logic, and
// the queue head is then loaded into the output register.
// Throughput: one item per cycle unless stalled; per-lane GF(2^8) multipliers are unrolled.
// Reset: synchronous rst clears factor, mode, word count, found flag, queue.
// ---------------------------------------------------------------------------
// gf256_region_multiply_accumulate_top
// GF(2^8) region multiply/accumulate over 8-byte words, polynomial 0x11d.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gf256_region_multiply_accumulate_top import gfmac_pkg::*; #(
  parameter int MAX_WORDS = 4096,
  parameter int LANES     = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [127:0]         s_tdata,   // src_word, old_dest_word
  input  logic                 s_tlast,   // last
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [79:0]          m_tdata,   // new_dest_word, nonzero_found, first_nonzero_index
  output logic                 m_tlast    // last_out
);

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  logic   q_not_empty;
  entry_t head;

  logic [WORD_W-1:0] new_dest_word;
  logic              nonzero_found;
  logic [IDX_W-1:0]  first_nonzero_index;

  gfmac_front #(
    .MAX_WORDS (MAX_WORDS),
    .LANES     (LANES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .src_word      (s_tdata[63:0]),
    .old_dest_word (s_tdata[127:64]),
    .last          (s_tlast),
    .push          (push),
    .push_entry    (push_entry),
    .q_full        (q_full)
  );

  gfmac_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  gfmac_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_not_empty         (q_not_empty),
    .head                (head),
    .pop                 (pop),
    .out_valid           (m_tvalid),
    .out_ready           (m_tready),
    .new_dest_word       (new_dest_word),
    .nonzero_found       (nonzero_found),
    .first_nonzero_index (first_nonzero_index),
    .last_out            (m_tlast)
  );

  assign m_tdata = {first_nonzero_index, nonzero_found, new_dest_word};

endmodule

@@ hdl/gfmac_front.sv @@
// ---------------------------------------------------------------------------
// gfmac_front
// Holds configuration, multiplies each lane and classifies the word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfmac_front import gfmac_pkg::*; #(
  parameter int MAX_WORDS = 4096,
  parameter int LANES     = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_W-1:0]    src_word,
  input  logic [WORD_W-1:0]    old_dest_word,
  input  logic                 last,
  output logic                 push,
  output entry_t               push_entry,
  input  logic                 q_full
);

  localparam int WC_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [WC_W-1:0] WC_MAX = WC_W'(MAX_WORDS - 1);

  logic [7:0]      factor;
  mode_t           mode;
  logic [WC_W-1:0] word_count;
  logic [WC_W-1:0] word_count_next;

  logic [7:0]        mult;
  logic              accumulate;
  logic [WORD_W-1:0] result;
  logic              nz_any;
  logic [LANE_W-1:0] nz_lane;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= 8'd0;
      mode   <= MODE_XOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FACTOR: factor <= cfg_data;
        CFG_MODE:   mode   <= mode_t'(cfg_data[1:0]);
        default:    ;
      endcase
    end
  end

  assign mult       = (mode == MODE_DIVIDE) ? GF_INV[factor] : factor;
  assign accumulate = (mode == MODE_XOR) || (mode == MODE_SEARCH);

  always_comb begin
    logic [7:0] r;
    result  = '0;
    nz_any  = 1'b0;
    nz_lane = '0;
    for (int l = 7; l >= 0; l--) begin
      if (l < LANES) begin
        r = gf_mul(src_word[l*8 +: 8], mult);
        if (accumulate) begin
          r = r ^ old_dest_word[l*8 +: 8];
        end
        result[l*8 +: 8] = r;
        if (r != 8'd0) begin
          nz_any  = 1'b1;
          nz_lane = LANE_W'(l);
        end
      end
    end
  end

  always_comb begin
    push_entry.word   = result;
    push_entry.nz_any = nz_any;
    push_entry.nz_idx = IDX_W'(32'(word_count) * LANES) + IDX_W'(nz_lane);
    push_entry.search = (mode == MODE_SEARCH);
    push_entry.last   = last;
  end

  always_comb begin
    if (last || word_count == WC_MAX) begin
      word_count_next = '0;
    end else begin
      word_count_next = word_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (push) begin
      word_count <= word_count_next;
    end
  end

endmodule

@@ hdl/gfmac_fifo.sv @@
// ---------------------------------------------------------------------------
// gfmac_fifo
// Two-entry queue between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfmac_fifo import gfmac_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/gfmac_back.sv @@
// ---------------------------------------------------------------------------
// gfmac_back
// Tracks the first nonzero byte of a buffer and drives the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfmac_back import gfmac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  entry_t            head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] new_dest_word,
  output logic              nonzero_found,
  output logic [IDX_W-1:0]  first_nonzero_index,
  output logic              last_out
);

  logic             found_flag;
  logic [IDX_W-1:0] found_index;
  logic             found_next;
  logic [IDX_W-1:0] index_next;

  assign pop = q_not_empty && (!out_valid || out_ready);

  always_comb begin
    found_next = found_flag;
    index_next = found_index;
    if (head.search && !found_flag && head.nz_any) begin
      found_next = 1'b1;
      index_next = head.nz_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      found_flag  <= 1'b0;
      found_index <= '0;
    end else begin
      if (pop) begin
        out_valid   <= 1'b1;
        found_flag  <= head.last ? 1'b0 : found_next;
        found_index <= index_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      new_dest_word       <= head.word;
      nonzero_found       <= found_next;
      first_nonzero_index <= found_next ? index_next : '0;
      last_out            <= head.last;
    end
  end

endmodule

@@ hdl/gfmac_checker.sv @@
// ---------------------------------------------------------------------------
// gfmac_checker
// Port-level checks for the region multiply-accumulate, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfmac_checker import gfmac_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_DAT_W-1:0] cfg_data,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [127:0]         s_tdata,
  input logic                 s_tlast,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [79:0]          m_tdata,
  input logic                 m_tlast
);

  logic             prev_found;
  logic             prev_last;
  logic [IDX_W-1:0] prev_idx;
  logic             out_acc;

  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_found <= 1'b0;
      prev_last  <= 1'b1;
      prev_idx   <= '0;
    end else if (out_acc) begin
      prev_found <= m_tdata[64];
      prev_last  <= m_tlast;
      prev_idx   <= m_tdata[79:65];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[64] |-> m_tdata[79:65] == '0)
    else $error("index nonzero without found flag");

  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    out_acc && prev_found && !prev_last |-> m_tdata[64] && m_tdata[79:65] == prev_idx)
    else $error("found index lost within a buffer");

endmodule

bind gf256_region_multiply_accumulate_top gfmac_checker u_gfmac_checker (.*);

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the GF(2^8) region multiply/accumulate block.
// A short table of directed items and register writes comes first, then
// random phases, each with a new factor and mode and a few buffers of words
// whose bytes are often zero or cancel, so that the first-nonzero search
// lands at varied positions. Every accepted item is predicted in the bench
// and each result is checked against the oldest prediction. Random bursts
// on the input side, random stall patterns and one long hold-off on the
// output side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import gfmac_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_ITEMS  = 1550;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic              is_last;
    logic [IDX_W-1:0]  idx;
    logic              found;
    logic [WORD_W-1:0] word;
  } dest_result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [7:0]        reg_idx;
    logic [7:0]        reg_val;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] old;
    logic              is_last;
    bit                typed;
    logic [WORD_W-1:0] exp_word;
    logic              exp_found;
    logic [IDX_W-1:0]  exp_idx;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [127:0]         s_tdata;   // src_word, old_dest_word
  logic                 s_tlast;   // last
  logic                 m_tvalid;
  logic                 m_tready;
  logic [79:0]          m_tdata;   // new_dest_word, nonzero_found, first_nonzero_index
  logic                 m_tlast;   // last_out

  gf256_region_multiply_accumulate_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // bench copy of the block state
  logic [7:0]       mdl_factor;
  mode_t            mdl_mode;
  logic [11:0]      mdl_word_cnt;
  logic             mdl_found;
  logic [IDX_W-1:0] mdl_found_idx;
  logic [7:0]       recip [256];

  dest_result_t dest_q [$];
  stim_row_t    dir_tbl [$];

  bit           typed_on;
  dest_result_t typed_exp;

  int n_err, n_cyc, n_cfg, n_res, n_found, n_bufs;
  int n_dir, n_rand;
  int burst_left;

  // receiver control
  bit          hold_req;
  int          hold_left, style_left, rx_style;
  logic [7:0]  rx_phase;
  logic        rx_next;

  function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] sh;
    prod = 8'h00;
    sh   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        prod = prod ^ sh;
      end
      sh = {sh[6:0], 1'b0} ^ (sh[7] ? 8'h1d : 8'h00);
    end
    return prod;
  endfunction

  task automatic predict_dest(input logic [WORD_W-1:0] src, input logic [WORD_W-1:0] old,
                              input logic is_last, output dest_result_t res);
    logic [7:0] mult;
    logic [7:0] r;
    bit         accum;
    bit         searching;
    mult      = (mdl_mode == MODE_DIVIDE) ? recip[mdl_factor] : mdl_factor;
    accum     = (mdl_mode == MODE_XOR) || (mdl_mode == MODE_SEARCH);
    searching = (mdl_mode == MODE_SEARCH) && !mdl_found;
    res.word  = '0;
    for (int lane = 0; lane < 8; lane++) begin
      r = gf_times(src[lane*8 +: 8], mult);
      if (accum) begin
        r = r ^ old[lane*8 +: 8];
      end
      res.word[lane*8 +: 8] = r;
      if (searching && r != 8'h00) begin
        mdl_found     = 1'b1;
        mdl_found_idx = {mdl_word_cnt, 3'(lane)};
        searching     = 1'b0;
      end
    end
    res.found   = mdl_found;
    res.idx     = mdl_found ? mdl_found_idx : '0;
    res.is_last = is_last;
    if (is_last) begin
      mdl_word_cnt = '0;
      mdl_found    = 1'b0;
    end else begin
      mdl_word_cnt = mdl_word_cnt + 12'd1;
    end
  endtask

  task automatic check_dest(input dest_result_t got);
    dest_result_t want;
    n_res++;
    if (got.found) begin
      n_found++;
    end
    if (dest_q.size() == 0) begin
      n_err++;
      if (n_err <= 10) begin
        $display("ERROR: unexpected result word=%h found=%b idx=%0d last=%b",
                 got.word, got.found, got.idx, got.is_last);
      end
    end else begin
      want = dest_q.pop_front();
      if (got.word !== want.word || got.found !== want.found || got.idx !== want.idx ||
          got.is_last !== want.is_last) begin
        n_err++;
        if (n_err <= 10) begin
          $display("ERROR: result %0d exp word=%h found=%b idx=%0d last=%b", n_res,
                   want.word, want.found, want.idx, want.is_last);
          $display("       got          word=%h found=%b idx=%0d last=%b",
                   got.word, got.found, got.idx, got.is_last);
        end
      end
    end
  endtask

  // all accepts are handled at the rising edge in one place
  always @(posedge clk) begin
    dest_result_t pred;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        if (cfg_index == CFG_FACTOR) begin
          mdl_factor = cfg_data;
        end else if (cfg_index == CFG_MODE) begin
          mdl_mode = mode_t'(cfg_data[1:0]);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_dest(s_tdata[63:0], s_tdata[127:64], s_tlast, pred);
        dest_q.push_back(typed_on ? typed_exp : pred);
        if (s_tlast) begin
          n_bufs++;
        end
      end
      if (m_tvalid && m_tready) begin
        check_dest({m_tlast, m_tdata[79:65], m_tdata[64], m_tdata[63:0]});
      end
    end
  end

  always @(posedge clk) begin
    n_cyc++;
    if (n_cyc > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results pending", n_cyc, dest_q.size());
      $display("** gf256_region_multiply_accumulate_top: FAILED **");
      $finish;
    end
  end

  // receiver: changing stall styles plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (style_left == 0) begin
      rx_style   = $urandom_range(0, 3);
      style_left = $urandom_range(16, 96);
    end else begin
      style_left--;
    end
    rx_phase = rx_phase + 8'd1;
    if (hold_left != 0) begin
      hold_left--;
      rx_next = 1'b0;
    end else begin
      case (rx_style)
        0: rx_next = 1'b1;
        1: rx_next = $urandom_range(0, 1);
        2: rx_next = ($urandom_range(0, 3) == 0);
        default: rx_next = (rx_phase[2:0] != 3'd0);
      endcase
    end
  end

  always @(negedge clk) begin
    m_tready <= rx_next;
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_word(input logic [WORD_W-1:0] src, input logic [WORD_W-1:0] old,
                           input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {old, src};
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    do @(negedge clk); while (dest_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // zero_pct of the lanes are all zero; other lanes often cancel to zero
  function automatic void make_item(input int zero_pct, output logic [WORD_W-1:0] src,
                                    output logic [WORD_W-1:0] old);
    logic [7:0] mult;
    logic [7:0] s;
    logic [7:0] d;
    int         r;
    mult = (mdl_mode == MODE_DIVIDE) ? recip[mdl_factor] : mdl_factor;
    for (int lane = 0; lane < 8; lane++) begin
      r = $urandom_range(0, 99);
      if (r < zero_pct) begin
        s = 8'h00;
        d = 8'h00;
      end else begin
        s = (r < zero_pct + 4) ? 8'hff : 8'($urandom);
        case ($urandom_range(0, 3))
          0: d = 8'h00;
          1: d = gf_times(s, mult);
          2: d = 8'hff;
          default: d = 8'($urandom);
        endcase
      end
      src[lane*8 +: 8] = s;
      old[lane*8 +: 8] = d;
    end
  endfunction

  function automatic stim_row_t item_row(logic [WORD_W-1:0] src, logic [WORD_W-1:0] old,
                                         logic is_last, bit typed, logic [WORD_W-1:0] w,
                                         logic found, logic [IDX_W-1:0] idx);
    stim_row_t row;
    row = '{ROW_ITEM, 8'h00, 8'h00, src, old, is_last, typed, w, found, idx};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [7:0] idx, logic [7:0] val);
    stim_row_t row;
    row = '{ROW_CFG, idx, val, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0};
    return row;
  endfunction

  initial begin
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] old;
    logic              is_last;
    int                nbuf, len, zero_pct;
    bit                hold_done;
    logic [7:0]        fct;
    mode_t             md;

    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    m_tready   = 1'b0;
    rx_next    = 1'b0;
    rx_phase   = '0;
    typed_on   = 1'b0;
    typed_exp  = '0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    mdl_factor = 8'h00;
    mdl_mode   = MODE_XOR;
    mdl_word_cnt  = '0;
    mdl_found     = 1'b0;
    mdl_found_idx = '0;
    recip[0] = 8'h00;
    for (int a = 1; a < 256; a++) begin
      for (int b = 1; b < 256; b++) begin
        if (gf_times(8'(a), 8'(b)) == 8'h01) begin
          recip[a] = 8'(b);
        end
      end
    end

    // reset values: factor 0, xor mode passes the old destination through
    dir_tbl.push_back(item_row('1, 64'h0123_4567_89ab_cdef, 1'b0,
                               1'b1, 64'h0123_4567_89ab_cdef, 1'b0, '0));
    dir_tbl.push_back(item_row('0, '1, 1'b1, 1'b1, '1, 1'b0, '0));
    dir_tbl.push_back(cfg_row(CFG_MODE, 8'(MODE_WRITE)));
    dir_tbl.push_back(item_row('1, '1, 1'b1, 1'b1, '0, 1'b0, '0));
    dir_tbl.push_back(cfg_row(CFG_FACTOR, 8'h01));
    dir_tbl.push_back(item_row(64'h0123_4567_89ab_cdef, '1, 1'b1,
                               1'b1, 64'h0123_4567_89ab_cdef, 1'b0, '0));
    dir_tbl.push_back(cfg_row(CFG_FACTOR, 8'hff));
    dir_tbl.push_back(cfg_row(CFG_MODE, 8'(MODE_XOR)));
    dir_tbl.push_back(item_row('1, '0, 1'b0, 1'b0, '0, 1'b0, '0));
    dir_tbl.push_back(item_row(64'h8080_8080_8080_8080, 64'h5555_5555_5555_5555, 1'b1,
                               1'b0, '0, 1'b0, '0));
    // divide by zero writes zero, divide by one copies the source
    dir_tbl.push_back(cfg_row(CFG_FACTOR, 8'h00));
    dir_tbl.push_back(cfg_row(CFG_MODE, 8'(MODE_DIVIDE)));
    dir_tbl.push_back(item_row('1, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b1, '0, 1'b0, '0));
    dir_tbl.push_back(cfg_row(CFG_FACTOR, 8'h01));
    dir_tbl.push_back(item_row(64'hdead_beef_0bad_f00d, '1, 1'b1,
                               1'b1, 64'hdead_beef_0bad_f00d, 1'b0, '0));
    dir_tbl.push_back(cfg_row(CFG_FACTOR, 8'h02));
    dir_tbl.push_back(item_row(64'hfedc_ba98_7654_3210, '0, 1'b1, 1'b0, '0, 1'b0, '0));
    dir_tbl.push_back(cfg_row(CFG_FACTOR, 8'hff));
    dir_tbl.push_back(item_row('1, '0, 1'b1, 1'b0, '0, 1'b0, '0));
    // search: first hit at byte 13, kept for the rest of the buffer
    dir_tbl.push_back(cfg_row(CFG_FACTOR, 8'h01));
    dir_tbl.push_back(cfg_row(CFG_MODE, 8'(MODE_SEARCH)));
    dir_tbl.push_back(item_row('0, '0, 1'b0, 1'b1, '0, 1'b0, '0));
    dir_tbl.push_back(item_row('0, 64'h0000_0100_0000_0000, 1'b0,
                               1'b1, 64'h0000_0100_0000_0000, 1'b1, 15'd13));
    dir_tbl.push_back(item_row('1, '0, 1'b0, 1'b1, '1, 1'b1, 15'd13));
    dir_tbl.push_back(item_row('0, '0, 1'b1, 1'b1, '0, 1'b1, 15'd13));
    // new buffer hides the old index; cancelling bytes are not a hit
    dir_tbl.push_back(item_row(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 1'b1,
                               1'b1, '0, 1'b0, '0));
    // counter runs in xor mode, search picks up mid-buffer
    dir_tbl.push_back(cfg_row(CFG_MODE, 8'(MODE_XOR)));
    dir_tbl.push_back(item_row('0, '0, 1'b0, 1'b1, '0, 1'b0, '0));
    dir_tbl.push_back(cfg_row(CFG_MODE, 8'(MODE_SEARCH)));
    dir_tbl.push_back(item_row('0, 64'h1, 1'b1, 1'b1, 64'h1, 1'b1, 15'd8));

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        drain();
        reg_write(dir_tbl[i].reg_idx, dir_tbl[i].reg_val);
      end else begin
        typed_on  = dir_tbl[i].typed;
        typed_exp = {dir_tbl[i].is_last, dir_tbl[i].exp_idx, dir_tbl[i].exp_found,
                     dir_tbl[i].exp_word};
        send_word(dir_tbl[i].src, dir_tbl[i].old, dir_tbl[i].is_last);
        typed_on  = 1'b0;
        n_dir++;
      end
    end

    // random phases, buffers may stay open across a register change
    while (n_rand < RAND_ITEMS) begin
      drain();
      case ($urandom_range(0, 5))
        0: fct = 8'h00;
        1: fct = 8'h01;
        2: fct = 8'hff;
        default: fct = 8'($urandom);
      endcase
      md = ($urandom_range(0, 2) == 0) ? MODE_SEARCH : mode_t'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
        reg_write(CFG_FACTOR, fct);
        reg_write(CFG_MODE, 8'(md));
      end else begin
        reg_write(CFG_MODE, 8'(md));
        reg_write(CFG_FACTOR, fct);
      end
      if (n_rand >= RAND_ITEMS / 2 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      case ($urandom_range(0, 3))
        0: zero_pct = 0;
        1: zero_pct = 40;
        2: zero_pct = 80;
        default: zero_pct = 97;
      endcase
      // enough words during the hold-off to fill the block
      nbuf = hold_req ? 6 : $urandom_range(1, 6);
      for (int b = 0; b < nbuf; b++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        for (int w = 0; w < len; w++) begin
          make_item(zero_pct, src, old);
          is_last = (w == len - 1) && !(b == nbuf - 1 && $urandom_range(0, 3) == 0);
          send_word(src, old, is_last);
          n_rand++;
        end
      end
    end

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (dest_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);

    if (dest_q.size() != 0) begin
      n_err++;
      $display("ERROR: %0d results never arrived", dest_q.size());
    end
    $display("Covered %0d items (%0d directed, %0d random), %0d buffers,",
             n_dir + n_rand, n_dir, n_rand, n_bufs);
    $display("%0d register writes, %0d results checked (%0d with a find), %0d mismatches.",
             n_cfg, n_res, n_found, n_err);
    if (n_err == 0) begin
      $display("** gf256_region_multiply_accumulate_top: PASSED **");
    end else begin
      $display("** gf256_region_multiply_accumulate_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/gfmac_pkg.sv
hdl/gfmac_front.sv
hdl/gfmac_fifo.sv
hdl/gfmac_back.sv
hdl/gf256_region_multiply_accumulate_top.sv
hdl/gfmac_checker.sv
bench/tb.sv
